[hdl/swtd_pkg.sv]
// ----------------------------------------------------------------------------
// swtd_pkg
// Shared types and constants for the square waypoint turn-then-drive block.
// ----------------------------------------------------------------------------
package swtd_pkg;

    localparam int CORNER_COUNT = 4;
    localparam int CORDIC_STEPS = 24;
    localparam int VEC_W        = 34;
    localparam int CORDIC_W     = 44;
    localparam int NORM_BIT     = 40;

    localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] CFG_SIDE      = 3'd2;
    localparam logic [2:0] CFG_POS_TOL   = 3'd3;
    localparam logic [2:0] CFG_HEAD_TOL  = 3'd4;
    localparam logic [2:0] CFG_FWD_SPEED = 3'd5;
    localparam logic [2:0] CFG_TURN_RATE = 3'd6;

    localparam logic [30:0] Q_QUARTER = 31'h4000_0000;
    localparam logic [31:0] Q_HALF    = 32'h8000_0000;

    // atan(2^-i) at 2^32 units per turn
    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    typedef struct packed {
        logic                    start;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
    } swtd_atan_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] angle;
    } swtd_atan_rsp_t;

endpackage

[hdl/swtd_atan2.sv]
// ----------------------------------------------------------------------------
// swtd_atan2
// Iterative atan2: normalize, 24-step vectoring CORDIC, clamp, quadrant map.
// Result in 2^32 units per turn, one done pulse per request.
// ----------------------------------------------------------------------------
module swtd_atan2 (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  swtd_pkg::swtd_atan_req_t req,
    output swtd_pkg::swtd_atan_rsp_t rsp
);
    import swtd_pkg::*;

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_NORM = 2'd1;
    localparam logic [1:0] U_ROT  = 2'd2;
    localparam logic [1:0] U_DONE = 2'd3;

    logic [1:0]                 ustate_reg, ustate_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [32:0]         z_reg, z_next;
    logic [4:0]                 step_reg, step_next;
    logic                       xneg_reg, xneg_next;
    logic                       yneg_reg, yneg_next;
    logic                       done_reg, done_next;
    logic [31:0]                angle_reg, angle_next;

    logic [VEC_W-1:0]           ax, ay;
    logic [CORDIC_W-1:0]        or_v;
    logic signed [CORDIC_W-1:0] sx, sy;
    logic signed [32:0]         atan_v;
    logic [30:0]                zc;
    logic [31:0]                q32;

    always_comb begin
        ax     = req.x[VEC_W-1] ? (VEC_W'(0) - req.x) : req.x;
        ay     = req.y[VEC_W-1] ? (VEC_W'(0) - req.y) : req.y;
        or_v   = x_reg | y_reg;
        sx     = y_reg >>> step_reg;
        sy     = x_reg >>> step_reg;
        atan_v = {3'b000, ATAN_TAB[step_reg]};
        if (z_reg[32]) begin
            zc = '0;
        end else if (z_reg > 33'sd1073741824) begin
            zc = Q_QUARTER;
        end else begin
            zc = z_reg[30:0];
        end
        q32 = {1'b0, zc};
    end

    always_comb begin
        ustate_next = ustate_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        step_next   = step_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        done_next   = 1'b0;
        angle_next  = angle_reg;
        case (ustate_reg)
            U_IDLE: begin
                if (req.start) begin
                    x_next    = {{(CORDIC_W-VEC_W){1'b0}}, ax};
                    y_next    = {{(CORDIC_W-VEC_W){1'b0}}, ay};
                    xneg_next = req.x[VEC_W-1];
                    yneg_next = req.y[VEC_W-1];
                    z_next    = '0;
                    step_next = '0;
                    if (ay == '0) begin
                        ustate_next = U_DONE;
                    end else if (ax == '0) begin
                        z_next      = {2'b00, Q_QUARTER};
                        ustate_next = U_DONE;
                    end else begin
                        ustate_next = U_NORM;
                    end
                end
            end
            U_NORM: begin
                if (or_v[NORM_BIT]) begin
                    ustate_next = U_ROT;
                end else if (or_v[NORM_BIT -: 8] == '0) begin
                    x_next = x_reg << 8;
                    y_next = y_reg << 8;
                end else if (or_v[NORM_BIT -: 4] == '0) begin
                    x_next = x_reg << 4;
                    y_next = y_reg << 4;
                end else if (or_v[NORM_BIT -: 2] == '0) begin
                    x_next = x_reg << 2;
                    y_next = y_reg << 2;
                end else begin
                    x_next = x_reg << 1;
                    y_next = y_reg << 1;
                end
            end
            U_ROT: begin
                if (!y_reg[CORDIC_W-1]) begin
                    x_next = x_reg + sx;
                    y_next = y_reg - sy;
                    z_next = z_reg + atan_v;
                end else begin
                    x_next = x_reg - sx;
                    y_next = y_reg + sy;
                    z_next = z_reg - atan_v;
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(CORDIC_STEPS - 1)) begin
                    ustate_next = U_DONE;
                end
            end
            U_DONE: begin
                case ({xneg_reg, yneg_reg})
                    2'b00:   angle_next = q32;
                    2'b10:   angle_next = Q_HALF - q32;
                    2'b11:   angle_next = Q_HALF + q32;
                    default: angle_next = 32'd0 - q32;
                endcase
                done_next   = 1'b1;
                ustate_next = U_IDLE;
            end
            default: ustate_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ustate_reg <= U_IDLE;
            done_reg   <= 1'b0;
        end else begin
            ustate_reg <= ustate_next;
            done_reg   <= done_next;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        step_reg  <= step_next;
        xneg_reg  <= xneg_next;
        yneg_reg  <= yneg_next;
        angle_reg <= angle_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.angle = angle_reg;

endmodule

[hdl/square_waypoint_turn_then_drive.sv]
// ----------------------------------------------------------------------------
// square_waypoint_turn_then_drive
// Square-path waypoint follower: turn toward the current corner, then drive.
// ----------------------------------------------------------------------------
// Input stream (s_): one pose request per item, x/y position and planar
// quaternion z/w. Output stream (m_): one result per request; m_tuser flags a
// velocity command (1) or a corner advance (0), m_tdata carries the speeds,
// the corner now targeted, and the heading and bearing angles.
// Config writes (cfg_we/cfg_addr/cfg_wdata) take effect at the clock edge and
// are meant for idle periods; unknown addresses are dropped.
// Both angles go through one shared iterative atan2 unit in turn; a pass
// does up to seven normalize shifts, a detect step, 24 CORDIC steps and a
// finish step, and a vector on an axis goes straight to the finish.
// s_tready is high only in the idle state, so a new request is taken only
// after the request before it has left the decide state.
// The result sits in an output register; the next request may be accepted
// while it waits, and a finished result then holds until m_tready frees it.
// Reset (synchronous, aresetn low) restores the register defaults, targets
// the first corner and empties the output register.
// ----------------------------------------------------------------------------
module square_waypoint_turn_then_drive #(
    parameter int ANGLE_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // pose_x, pose_y, quat_z, quat_w
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // linear_speed, angular_speed, corner_index,
                                    // heading_angle, bearing_angle, zero pad
    output logic [0:0]   m_tuser,   // command_valid
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    import swtd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HEAD   = 3'd1;
    localparam logic [2:0] S_HWAIT  = 3'd2;
    localparam logic [2:0] S_BWAIT  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    localparam logic [32:0]           BAM_ROUND = 33'd1 << (31 - ANGLE_BITS);
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    logic [2:0]               state_reg, state_next;
    logic signed [31:0]       origin_x_reg, origin_x_next;
    logic signed [31:0]       origin_y_reg, origin_y_next;
    logic [30:0]              side_reg, side_next;
    logic [30:0]              pos_tol_reg, pos_tol_next;
    logic [14:0]              head_tol_reg, head_tol_next;
    logic signed [31:0]       fwd_speed_reg, fwd_speed_next;
    logic [30:0]              turn_rate_reg, turn_rate_next;
    logic [1:0]               corner_reg, corner_next;

    logic signed [31:0]       pose_x_reg, pose_x_next;
    logic signed [31:0]       pose_y_reg, pose_y_next;
    logic signed [15:0]       quat_z_reg, quat_z_next;
    logic signed [15:0]       quat_w_reg, quat_w_next;
    logic signed [VEC_W-1:0]  dx_reg, dx_next;
    logic signed [VEC_W-1:0]  dy_reg, dy_next;
    logic                     arrive_reg, arrive_next;
    logic [ANGLE_BITS-1:0]    head_reg, head_next;
    logic [ANGLE_BITS-1:0]    bear_reg, bear_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [103:0]             m_tdata_reg, m_tdata_next;
    logic                     m_tuser_reg, m_tuser_next;

    swtd_atan_req_t           atan_req;
    swtd_atan_rsp_t           atan_rsp;

    logic signed [VEC_W-1:0]  cx, cy;
    logic [VEC_W-1:0]         adx, ady;
    logic [32:0]              head_sum, bear_sum;
    logic [ANGLE_BITS-1:0]    err, err_mag;
    logic                     left;
    logic                     turn;
    logic                     out_free;
    logic [31:0]              lin_v, ang_v;
    logic [1:0]               corner_out;
    logic                     valid_v;

    swtd_atan2 u_atan2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (atan_req),
        .rsp     (atan_rsp)
    );

    always_comb begin
        cx = {{2{origin_x_reg[31]}}, origin_x_reg}
             - ((corner_reg[1]) ? {3'b000, side_reg} : '0);
        cy = {{2{origin_y_reg[31]}}, origin_y_reg}
             + ((corner_reg == 2'd1 || corner_reg == 2'd2) ? {3'b000, side_reg} : '0);

        adx = dx_reg[VEC_W-1] ? (VEC_W'(0) - dx_reg) : dx_reg;
        ady = dy_reg[VEC_W-1] ? (VEC_W'(0) - dy_reg) : dy_reg;

        head_sum = {1'b0, atan_rsp.angle[30:0], 1'b0} + BAM_ROUND;
        bear_sum = {1'b0, atan_rsp.angle} + BAM_ROUND;

        err     = bear_reg - head_reg;
        left    = (err <= HALF_TURN);
        err_mag = left ? err : (ANGLE_BITS'(0) - err);
        turn    = (32'(err_mag) > 32'(head_tol_reg));

        out_free = !m_tvalid_reg || m_tready;

        atan_req.start = (state_reg == S_HEAD) || (state_reg == S_HWAIT && atan_rsp.done);
        atan_req.x     = (state_reg == S_HEAD) ? {{(VEC_W-16){quat_w_reg[15]}}, quat_w_reg}
                                               : dx_reg;
        atan_req.y     = (state_reg == S_HEAD) ? {{(VEC_W-16){quat_z_reg[15]}}, quat_z_reg}
                                               : dy_reg;

        if (arrive_reg) begin
            valid_v    = 1'b0;
            lin_v      = '0;
            ang_v      = '0;
            corner_out = corner_reg + 2'd1;
        end else begin
            valid_v    = 1'b1;
            corner_out = corner_reg;
            if (turn) begin
                lin_v = '0;
                ang_v = left ? {1'b0, turn_rate_reg} : (32'd0 - {1'b0, turn_rate_reg});
            end else begin
                lin_v = fwd_speed_reg;
                ang_v = '0;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        origin_x_next  = origin_x_reg;
        origin_y_next  = origin_y_reg;
        side_next      = side_reg;
        pos_tol_next   = pos_tol_reg;
        head_tol_next  = head_tol_reg;
        fwd_speed_next = fwd_speed_reg;
        turn_rate_next = turn_rate_reg;
        corner_next    = corner_reg;
        pose_x_next    = pose_x_reg;
        pose_y_next    = pose_y_reg;
        quat_z_next    = quat_z_reg;
        quat_w_next    = quat_w_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        arrive_next    = arrive_reg;
        head_next      = head_reg;
        bear_next      = bear_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (cfg_we) begin
            case (cfg_addr)
                CFG_ORIGIN_X:  origin_x_next  = cfg_wdata;
                CFG_ORIGIN_Y:  origin_y_next  = cfg_wdata;
                CFG_SIDE:      side_next      = cfg_wdata[30:0];
                CFG_POS_TOL:   pos_tol_next   = cfg_wdata[30:0];
                CFG_HEAD_TOL:  head_tol_next  = cfg_wdata[14:0];
                CFG_FWD_SPEED: fwd_speed_next = cfg_wdata;
                CFG_TURN_RATE: turn_rate_next = cfg_wdata[30:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    pose_x_next = s_tdata[31:0];
                    pose_y_next = s_tdata[63:32];
                    quat_z_next = s_tdata[79:64];
                    quat_w_next = s_tdata[95:80];
                    state_next  = S_HEAD;
                end
            end
            S_HEAD: begin
                dx_next    = cx - {{2{pose_x_reg[31]}}, pose_x_reg};
                dy_next    = cy - {{2{pose_y_reg[31]}}, pose_y_reg};
                state_next = S_HWAIT;
            end
            S_HWAIT: begin
                arrive_next = (adx <= {3'b000, pos_tol_reg}) && (ady <= {3'b000, pos_tol_reg});
                if (atan_rsp.done) begin
                    head_next  = head_sum[31 -: ANGLE_BITS];
                    state_next = S_BWAIT;
                end
            end
            S_BWAIT: begin
                if (atan_rsp.done) begin
                    bear_next  = bear_sum[31 -: ANGLE_BITS];
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = valid_v;
                    m_tdata_next  = {6'b0, 16'(bear_reg), 16'(head_reg), corner_out,
                                     ang_v, lin_v};
                    corner_next   = corner_out;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            origin_x_reg  <= 32'sd196608;
            origin_y_reg  <= 32'sd0;
            side_reg      <= 31'd196608;
            pos_tol_reg   <= 31'd6554;
            head_tol_reg  <= 15'd1043;
            fwd_speed_reg <= 32'sd65536;
            turn_rate_reg <= 31'd65536;
            corner_reg    <= 2'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            origin_x_reg  <= origin_x_next;
            origin_y_reg  <= origin_y_next;
            side_reg      <= side_next;
            pos_tol_reg   <= pos_tol_next;
            head_tol_reg  <= head_tol_next;
            fwd_speed_reg <= fwd_speed_next;
            turn_rate_reg <= turn_rate_next;
            corner_reg    <= corner_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        pose_x_reg  <= pose_x_next;
        pose_y_reg  <= pose_y_next;
        quat_z_reg  <= quat_z_next;
        quat_w_reg  <= quat_w_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        arrive_reg  <= arrive_next;
        head_reg    <= head_next;
        bear_reg    <= bear_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // busy for the whole request once taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a request while one is in flight");

    a_advance_no_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[63:0] == 64'd0)
        else $error("corner advance carries a motion command");

    a_turn_or_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:0] == 32'd0 || m_tdata[63:32] == 32'd0))
        else $error("turn and drive commanded together");

    a_corner_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(corner_reg) |-> $past(state_reg) == S_DECIDE)
        else $error("target corner changed outside the decide step");

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for square_waypoint_turn_then_drive. Pose requests
// go in on s_ with random gaps; results are taken on m_ with random
// back-pressure. Each result is checked against a bit-exact predictor of the
// corner tracking and of the CORDIC heading and bearing logic. The run covers
// a directed set and several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swtd_pkg::*;

    localparam int         RUN_LIMIT   = 1_000_000;
    localparam int         PHASES      = 6;
    localparam int         PHASE_ITEMS = 125;
    localparam logic [2:0] CFG_NONE    = 3'd7;

    // atan(2^-i), 2^32 units per turn
    localparam longint ATAN_STEP_TURN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        int      px;
        int      py;
        shortint qz;
        shortint qw;
    } pose_t;

    typedef struct {
        bit        valid;
        bit [31:0] lin;
        bit [31:0] ang;
        bit [1:0]  corner;
        bit [15:0] head;
        bit [15:0] bear;
    } steer_t;

    typedef enum {POSE_ARRIVE, POSE_EDGE, POSE_AIMED, POSE_WILD} pose_kind_t;

    class steer_predictor;
        longint   org_x, org_y, fwd_speed;
        longint   side, pos_tol, head_tol, turn_mag;
        bit [1:0] corner;
        steer_t   queued_cmds[$];
        int       mismatches;

        function new();
            org_x     = 196608;
            org_y     = 0;
            side      = 196608;
            pos_tol   = 6554;
            head_tol  = 1043;
            fwd_speed = 65536;
            turn_mag  = 65536;
            corner    = 0;
        endfunction

        function void set_register(logic [2:0] idx, bit [31:0] v);
            case (idx)
                CFG_ORIGIN_X:  org_x = signed'(v);
                CFG_ORIGIN_Y:  org_y = signed'(v);
                CFG_SIDE:      side = v[30:0];
                CFG_POS_TOL:   pos_tol = v[30:0];
                CFG_HEAD_TOL:  head_tol = v[14:0];
                CFG_FWD_SPEED: fwd_speed = signed'(v);
                CFG_TURN_RATE: turn_mag = v[30:0];
                default: ;
            endcase
        endfunction

        function void corner_xy(output longint cx, output longint cy);
            cx = org_x - ((corner >= 2) ? side : 0);
            cy = org_y + ((corner == 1 || corner == 2) ? side : 0);
        endfunction

        // atan2(y, x), 2^32 units per turn
        function longint unsigned atan2_turn(longint x, longint y);
            longint unsigned ax, ay, m, q, r;
            longint          vx, vy, vz, tx;
            int              n, i;
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            if (ax == 0 && ay == 0) return 0;
            if (ay == 0) begin
                q = 0;
            end else if (ax == 0) begin
                q = 64'd1 << 30;
            end else begin
                m = (ax > ay) ? ax : ay;
                n = 0;
                while (m < (64'd1 << 40)) begin
                    m = m << 1;
                    n++;
                end
                vx = ax << n;
                vy = ay << n;
                vz = 0;
                for (i = 0; i < 24; i++) begin
                    tx = vx;
                    if (vy >= 0) begin
                        vx = vx + (vy >>> i);
                        vy = vy - (tx >>> i);
                        vz = vz + ATAN_STEP_TURN[i];
                    end else begin
                        vx = vx - (vy >>> i);
                        vy = vy + (tx >>> i);
                        vz = vz - ATAN_STEP_TURN[i];
                    end
                end
                if (vz < 0) vz = 0;
                if (vz > (64'sd1 << 30)) vz = 64'sd1 << 30;
                q = vz;
            end
            if (x >= 0 && y >= 0) r = q;
            else if (x < 0 && y >= 0) r = (64'd1 << 31) - q;
            else if (x < 0) r = (64'd1 << 31) + q;
            else r = (64'd1 << 32) - q;
            return r & 64'hFFFF_FFFF;
        endfunction

        function bit [15:0] binary_angle(longint unsigned a);
            return 16'((a + 32768) >> 16);
        endfunction

        function bit [15:0] bearing_from(int px, int py);
            longint cx, cy;
            corner_xy(cx, cy);
            return binary_angle(atan2_turn(cx - px, cy - py));
        endfunction

        function void note_request(pose_t p);
            steer_t    e;
            longint    cx, cy, adx, ady;
            bit [15:0] e16;
            int        err_mag;
            corner_xy(cx, cy);
            adx = cx - p.px;
            ady = cy - p.py;
            if (adx < 0) adx = -adx;
            if (ady < 0) ady = -ady;
            e = '{default: 0};
            e.head = binary_angle((atan2_turn(p.qw, p.qz) << 1) & 64'hFFFF_FFFF);
            e.bear = bearing_from(p.px, p.py);
            if (adx <= pos_tol && ady <= pos_tol) begin
                corner = corner + 2'd1;
            end else begin
                e16 = e.bear - e.head;
                err_mag = (e16 <= 16'h8000) ? int'(e16) : 65536 - int'(e16);
                e.valid = 1;
                if (err_mag > head_tol)
                    e.ang = (e16 <= 16'h8000) ? turn_mag[31:0] : -turn_mag[31:0];
                else
                    e.lin = fwd_speed[31:0];
            end
            e.corner = corner;
            queued_cmds.push_back(e);
        endfunction

        function void compare_field(string name, longint unsigned want,
                                    longint unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t %s mismatch: expected %0h actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(steer_t got);
            steer_t want;
            if (queued_cmds.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result: expected none actual %0h %0h %0h",
                         $time, got.valid, got.lin, got.ang);
                return;
            end
            want = queued_cmds.pop_front();
            compare_field("command_valid", want.valid, got.valid);
            compare_field("linear_speed", want.lin, got.lin);
            compare_field("angular_speed", want.ang, got.ang);
            compare_field("corner_index", want.corner, got.corner);
            compare_field("heading_angle", want.head, got.head);
            compare_field("bearing_angle", want.bear, got.bear);
        endfunction

        function int pending();
            return queued_cmds.size();
        endfunction
    endclass

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [103:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_we    = 1'b0;
    logic [2:0]   cfg_addr  = '0;
    logic [31:0]  cfg_wdata = '0;

    steer_predictor steer;
    int             send_pct;
    int             stall_pct;
    int             ready_left;

    square_waypoint_turn_then_drive dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int gap_len();
        return ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(4, 1);
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic pose_t make_pose(pose_kind_t kind);
        pose_t     p;
        longint    cx, cy, tol, ox, oy, t;
        int        ht, mag;
        bit [15:0] aim;
        real       half;
        tol = steer.pos_tol;
        ht  = int'(steer.head_tol);
        steer.corner_xy(cx, cy);
        p.qz = shortint'(int'($urandom_range(32768)) - 16384);
        p.qw = shortint'(int'($urandom_range(32768)) - 16384);
        ox = longint'($urandom_range(32'(tol * 2))) - tol;
        oy = longint'($urandom_range(32'(tol * 2))) - tol;
        if (kind == POSE_EDGE) begin
            ox = tol + longint'($urandom_range(1));
            if ($urandom_range(1)) ox = -ox;
            if ($urandom_range(1)) begin
                t = ox;
                ox = oy;
                oy = t;
            end
        end else if (kind == POSE_AIMED) begin
            case ($urandom_range(3))
                0: t = 23;
                1: t = 15;
                2: t = 7;
                default: t = 0;
            endcase
            ox = longint'(int'($urandom)) >>> t;
            oy = longint'(int'($urandom)) >>> t;
        end
        p.px = clamp32(cx + ox);
        p.py = clamp32(cy + oy);
        if (kind == POSE_WILD) begin
            p.px = $urandom;
            p.py = $urandom;
        end
        if (kind == POSE_AIMED) begin
            aim = steer.bearing_from(p.px, p.py);
            case ($urandom_range(3))
                0, 1: aim = 16'(int'(aim) + int'($urandom_range(2 * ht + 6)) - (ht + 3));
                2: aim = 16'(int'(aim) + 32768 + int'($urandom_range(6)) - 3);
                default: aim = 16'($urandom);
            endcase
            mag  = $urandom_range(16384, 1);
            half = aim * 3.14159265358979 / 65536.0;
            p.qz = shortint'($rtoi(mag * $sin(half)));
            p.qw = shortint'($rtoi(mag * $cos(half)));
        end
        return p;
    endfunction

    task automatic send_pose(pose_t p);
        int gap;
        s_tdata  <= {p.qw, p.qz, p.py, p.px};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        steer.note_request(p);
        gap = ($urandom_range(99) < send_pct) ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic await_drain();
        s_tvalid <= 1'b0;
        while (steer.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, bit [31:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        steer.set_register(idx, v);
    endtask

    task automatic configure(int phase);
        case (phase)
            1: begin
                send_pct  = 0;
                stall_pct = 0;
                write_reg(CFG_ORIGIN_X, int'($urandom) >>> 11);
                write_reg(CFG_ORIGIN_Y, int'($urandom) >>> 11);
                write_reg(CFG_SIDE, $urandom_range(1 << 22));
                write_reg(CFG_POS_TOL, $urandom_range(1 << 16));
                write_reg(CFG_HEAD_TOL, $urandom_range(4096));
                write_reg(CFG_FWD_SPEED, $urandom);
                write_reg(CFG_TURN_RATE, $urandom >> 1);
            end
            2: begin
                send_pct  = 50;
                stall_pct = 50;
                write_reg(CFG_ORIGIN_X, 32'h8000_0000);
                write_reg(CFG_ORIGIN_Y, 32'h8000_0000);
                write_reg(CFG_SIDE, 32'h0);
                write_reg(CFG_POS_TOL, 32'h0);
                write_reg(CFG_HEAD_TOL, 32'h0);
                write_reg(CFG_FWD_SPEED, 32'h8000_0000);
                write_reg(CFG_TURN_RATE, 32'h0);
                write_reg(CFG_NONE, $urandom);
            end
            3: begin
                send_pct  = 20;
                stall_pct = 60;
                write_reg(CFG_ORIGIN_X, 32'h7FFF_FFFF);
                write_reg(CFG_ORIGIN_Y, 32'h7FFF_FFFF);
                write_reg(CFG_SIDE, 32'hFFFF_FFFF);
                write_reg(CFG_POS_TOL, 32'h0000_4000);
                write_reg(CFG_HEAD_TOL, 32'hFFFF_FFFF);
                write_reg(CFG_FWD_SPEED, 32'h7FFF_FFFF);
                write_reg(CFG_TURN_RATE, 32'hFFFF_FFFF);
            end
            4: begin
                send_pct  = 60;
                stall_pct = 20;
                write_reg(CFG_ORIGIN_X, 32'h0);
                write_reg(CFG_ORIGIN_Y, 32'h0);
                write_reg(CFG_SIDE, $urandom_range(1 << 20));
                write_reg(CFG_POS_TOL, 32'h7FFF_FFFF);
                write_reg(CFG_HEAD_TOL, $urandom_range(32767));
                write_reg(CFG_FWD_SPEED, $urandom);
                write_reg(CFG_TURN_RATE, $urandom);
            end
            5: begin
                send_pct  = 40;
                stall_pct = 40;
                write_reg(CFG_ORIGIN_X, $urandom);
                write_reg(CFG_ORIGIN_Y, $urandom);
                write_reg(CFG_SIDE, $urandom);
                write_reg(CFG_POS_TOL, $urandom_range(1 << 24));
                write_reg(CFG_HEAD_TOL, 1043);
                write_reg(CFG_FWD_SPEED, $urandom);
                write_reg(CFG_TURN_RATE, $urandom);
            end
            default: begin
                send_pct  = 30;
                stall_pct = 30;
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    // result side: check, then pick the next ready pattern
    always @(posedge aclk) begin
        steer_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.valid  = m_tuser[0];
                got.lin    = m_tdata[31:0];
                got.ang    = m_tdata[63:32];
                got.corner = m_tdata[65:64];
                got.head   = m_tdata[81:66];
                got.bear   = m_tdata[97:82];
                steer.check_result(got);
            end
            if (ready_left == 0) begin
                if ($urandom_range(99) < stall_pct) begin
                    m_tready <= 1'b0;
                    ready_left = gap_len();
                end else begin
                    m_tready <= 1'b1;
                    ready_left = $urandom_range(8, 1);
                end
            end else begin
                ready_left--;
            end
        end
    end

    initial begin
        repeat (RUN_LIMIT) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int         ph, n, r;
        pose_kind_t kind;
        steer      = new();
        ready_left = 0;
        send_pct   = 30;
        stall_pct  = 30;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default square: corners (3,0) (3,3) (0,3) (0,0)
        send_pose('{0, 0, 0, 16384});
        send_pose('{0, 0, 0, 0});
        send_pose('{0, 0, 16384, 0});
        send_pose('{0, 0, -11585, 11585});
        send_pose('{0, 0, 11585, 11585});
        send_pose('{32'sh7FFF_FFFF, 32'sh8000_0000, 16384, 16384});
        send_pose('{32'sh8000_0000, 32'sh7FFF_FFFF, -16384, -16384});
        send_pose('{196608, 0, 0, 16384});
        send_pose('{196608, 0, 16384, 0});
        send_pose('{196608, 0, 11585, 11585});
        send_pose('{203162, 190054, 16384, -16384});
        send_pose('{6555, 196608, 0, 16384});
        send_pose('{-6554, 203162, 0, -16384});
        send_pose('{0, 100000, 0, 16384});
        send_pose('{0, 0, 1, 0});
        send_pose('{0, 0, 1, 1});
        send_pose('{0, 0, 16384, 1});
        send_pose('{0, 0, -1, -16384});
        send_pose('{-196608, -196608, 5, -3});
        await_drain();

        for (ph = 0; ph < PHASES; ph++) begin
            configure(ph);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && ph[0]) await_drain();
                r = $urandom_range(99);
                kind = (r < 25) ? POSE_ARRIVE :
                       (r < 35) ? POSE_EDGE :
                       (r < 85) ? POSE_AIMED : POSE_WILD;
                send_pose(make_pose(kind));
            end
            await_drain();
        end

        repeat (100) @(posedge aclk);
        if (steer.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
